[rtl/pyrd_pkg.sv]
// Shared types, constants and byte functions of the UYVY reorder deinterlacer.
package pyrd_pkg;

  localparam int MAX_PAIRS_DEF = 1024;
  localparam int PAIRS_W       = 11;
  localparam int LINES_W       = 12;
  localparam int QUEUE_DEPTH   = 4;
  localparam int OUT_DEPTH     = 2;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  localparam logic [1:0] REG_ORDER_MODE = 2'd0;
  localparam logic [1:0] REG_PAIRS      = 2'd1;
  localparam logic [1:0] REG_LINES      = 2'd2;

  localparam logic ORDER_YVYU = 1'b0;
  localparam logic ORDER_VYUY = 1'b1;

  localparam logic [PAIRS_W-1:0] PAIRS_RESET = PAIRS_W'(320);
  localparam logic [LINES_W-1:0] LINES_RESET = LINES_W'(480);

  typedef struct packed {
    logic [7:0] in_y1;
    logic [7:0] in_v;
    logic [7:0] in_y0;
    logic [7:0] in_u;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic       last_of_run;
    logic       end_of_frame;
  } out_item_t;

  typedef struct packed {
    logic               order_mode;
    logic [PAIRS_W-1:0] pairs_per_line;
    logic [LINES_W-1:0] line_count;
  } cfg_t;

  typedef struct packed {
    logic [31:0] above;
    logic [31:0] center;
    logic [31:0] cur;
    logic        use_copy;
    logic        two;
    logic        last_col;
  } work_t;

  function automatic logic [7:0] blend_byte(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic [8:0] s1;
    logic [8:0] s2;
    s1 = ({1'b0, a} + {1'b0, b} + 9'd1) >> 1;
    s2 = (s1 + {1'b0, c} + 9'd1) >> 1;
    return s2[7:0];
  endfunction

  function automatic logic [31:0] blend_word(input logic [31:0] above, input logic [31:0] center,
                                             input logic [31:0] below);
    logic [31:0] r;
    for (int k = 0; k < 4; k++) begin
      r[8*k +: 8] = blend_byte(above[8*k +: 8], below[8*k +: 8], center[8*k +: 8]);
    end
    return r;
  endfunction

  function automatic out_item_t reorder(input logic [31:0] w, input logic mode,
                                        input logic last, input logic eof);
    out_item_t o;
    if (mode == ORDER_YVYU) begin
      o.out_byte0 = w[15:8];
      o.out_byte1 = w[23:16];
      o.out_byte2 = w[31:24];
      o.out_byte3 = w[7:0];
    end else begin
      o.out_byte0 = w[23:16];
      o.out_byte1 = w[15:8];
      o.out_byte2 = w[7:0];
      o.out_byte3 = w[31:24];
    end
    o.last_of_run  = last;
    o.end_of_frame = eof;
    return o;
  endfunction

endpackage

[rtl/pyrd_fifo.sv]
// Small register queue with level output.
module pyrd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [W-1:0]                   din,
  input  logic                           pop,
  output logic [W-1:0]                   dout,
  output logic                           full,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     level
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (level_r == LW'(DEPTH));
  assign empty   = (level_r == '0);
  assign level   = level_r;
  assign dout    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + LW'(1);
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

[rtl/pyrd_front.sv]
// Front end: input transfer, line position tracking, line stores and classification.
module pyrd_front #(
  parameter int MAX_PAIRS = pyrd_pkg::MAX_PAIRS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  pyrd_pkg::cfg_t                            cfg,
  input  logic                                      in_push,
  input  pyrd_pkg::in_item_t                        in_data,
  output logic                                      in_full,
  input  logic [$clog2(pyrd_pkg::QUEUE_DEPTH+1)-1:0] q_level,
  output logic                                      q_push,
  output pyrd_pkg::work_t                           q_entry
);
  import pyrd_pkg::*;

  localparam int CW   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int CMPW = (CW + 1 > PAIRS_W) ? CW + 1 : PAIRS_W;
  localparam int LVW  = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]      col_r, col_nxt;
  logic [LINES_W-1:0] row_r, row_nxt;

  logic [31:0] one_back_mem [MAX_PAIRS];
  logic [31:0] two_back_mem [MAX_PAIRS];

  logic [31:0]  center_rd_r;
  logic [31:0]  above_rd_r;
  logic [31:0]  fwd_data_r;
  logic         fwd_r;
  logic         s1_valid_r;
  logic [CW-1:0] s1_col_r;
  logic [31:0]  s1_cur_r;
  logic         s1_row_zero_r;
  logic         s1_use_copy_r;
  logic         s1_two_r;
  logic         s1_last_col_r;

  logic               accept;
  logic [CMPW-1:0]    pairs_eff;
  logic [LINES_W-1:0] lines_eff;
  logic               last_col;
  logic               last_row;

  assign in_full = ({1'b0, q_level} + (LVW + 1)'(s1_valid_r)) >= (LVW + 1)'(QUEUE_DEPTH);
  assign accept  = in_push && !in_full;

  always_comb begin
    pairs_eff = CMPW'(cfg.pairs_per_line);
    if (pairs_eff == '0) begin
      pairs_eff = CMPW'(1);
    end else if (pairs_eff > CMPW'(MAX_PAIRS)) begin
      pairs_eff = CMPW'(MAX_PAIRS);
    end
    lines_eff = (cfg.line_count < LINES_W'(2)) ? LINES_W'(2) : cfg.line_count;
    last_col  = (CMPW'(col_r) + CMPW'(1)) >= pairs_eff;
    last_row  = row_r >= (lines_eff - LINES_W'(1));
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + LINES_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      one_back_mem[col_r] <= in_data;
      center_rd_r         <= one_back_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      two_back_mem[s1_col_r] <= center_rd_r;
    end
    if (accept) begin
      above_rd_r <= two_back_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_r         <= s1_valid_r && (s1_col_r == col_r);
      fwd_data_r    <= center_rd_r;
      s1_col_r      <= col_r;
      s1_cur_r      <= in_data;
      s1_row_zero_r <= (row_r == '0);
      s1_use_copy_r <= (row_r == LINES_W'(1));
      s1_two_r      <= last_row;
      s1_last_col_r <= last_col;
    end
  end

  always_comb begin
    q_push           = s1_valid_r && !s1_row_zero_r;
    q_entry.above    = fwd_r ? fwd_data_r : above_rd_r;
    q_entry.center   = center_rd_r;
    q_entry.cur      = s1_cur_r;
    q_entry.use_copy = s1_use_copy_r;
    q_entry.two      = s1_two_r;
    q_entry.last_col = s1_last_col_r;
  end

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_level < LVW'(QUEUE_DEPTH)))
    else $error("front pushes into a full queue");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_col && last_row) |=> (col_r == '0 && row_r == '0))
    else $error("frame does not restart after last row");

  a_row_zero_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && row_r == '0) |=> !q_push)
    else $error("row zero item produced work");

endmodule

[rtl/pyrd_back.sv]
// Back end: blend or copy, byte reorder and result issue, one or two results per item.
module pyrd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  pyrd_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  pyrd_pkg::work_t     q_head,
  output logic                q_pop,
  input  logic                o_full,
  output logic                o_push,
  output pyrd_pkg::out_item_t o_item
);
  import pyrd_pkg::*;

  logic        phase_r, phase_nxt;
  logic [31:0] word;
  logic        last;
  logic        eof;

  always_comb begin
    o_push = !q_empty && !o_full;
    if (phase_r) begin
      word = q_head.cur;
      last = 1'b1;
      eof  = q_head.last_col;
    end else begin
      word = q_head.use_copy ? q_head.center
                             : blend_word(q_head.above, q_head.center, q_head.cur);
      last = !q_head.two;
      eof  = 1'b0;
    end
    o_item    = reorder(word, cfg.order_mode, last, eof);
    q_pop     = o_push && (!q_head.two || phase_r);
    phase_nxt = o_push ? (q_head.two && !phase_r) : phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  a_phase_owner: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (!q_empty && q_head.two))
    else $error("second result pending without a last-row item");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (o_push && o_item.end_of_frame) |-> o_item.last_of_run)
    else $error("end of frame on a non-final result");

  a_pop_emits: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> o_push)
    else $error("item dropped without a result");

endmodule

[rtl/packed_yuv_reorder_deinterlace_core.sv]
// Top level: configuration registers, front end, work queue, back end and result queue.
//
//  channel  | ports                       | transfer when
//  ---------+-----------------------------+----------------------------------------
//  input    | in_push in_full in_data     | in_push && !in_full
//  result   | out_pop out_empty out_data  | out_pop && !out_empty
//  config   | cfg_psel .. cfg_pready      | cfg_psel && cfg_penable && cfg_pwrite
//
// One item per cycle while neither queue is full; items of the last row give two results
// each, as the back end writes one result per cycle to the result queue when it has room.
// A result is registered in the input stage, the work queue and the result queue in turn.
// Synchronous active-low reset clears counters and queues; line stores are not cleared.
// The input side stalls only when the work queue plus the stage in flight is full.
module packed_yuv_reorder_deinterlace_core #(
  parameter int MAX_PAIRS = pyrd_pkg::MAX_PAIRS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  pyrd_pkg::in_item_t          in_data,
  output logic                        out_empty,
  input  logic                        out_pop,
  output pyrd_pkg::out_item_t         out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pyrd_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [pyrd_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [pyrd_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import pyrd_pkg::*;

  localparam int LVW  = $clog2(QUEUE_DEPTH + 1);
  localparam int OLVW = $clog2(OUT_DEPTH + 1);

  logic               order_mode_r;
  logic [PAIRS_W-1:0] pairs_r;
  logic [LINES_W-1:0] lines_r;
  cfg_t               cfg;
  logic               cfg_wr;

  logic                     q_push;
  logic                     q_pop;
  logic                     q_full;
  logic                     q_empty;
  logic [LVW-1:0]           q_level;
  work_t                    q_entry;
  work_t                    q_head;
  logic [$bits(work_t)-1:0] q_dout;

  logic                         o_push;
  logic                         o_full;
  logic [OLVW-1:0]              o_level;
  out_item_t                    o_item;
  logic [$bits(out_item_t)-1:0] o_dout;

  assign cfg_pready     = 1'b1;
  assign cfg_wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg.order_mode     = order_mode_r;
  assign cfg.pairs_per_line = pairs_r;
  assign cfg.line_count     = lines_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_mode_r <= ORDER_YVYU;
      pairs_r      <= PAIRS_RESET;
      lines_r      <= LINES_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_ORDER_MODE: order_mode_r <= cfg_pwdata[0];
        REG_PAIRS:      pairs_r      <= cfg_pwdata[PAIRS_W-1:0];
        REG_LINES:      lines_r      <= cfg_pwdata[LINES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_ORDER_MODE: cfg_prdata = DATA_W'(order_mode_r);
      REG_PAIRS:      cfg_prdata = DATA_W'(pairs_r);
      REG_LINES:      cfg_prdata = DATA_W'(lines_r);
      default:        cfg_prdata = '0;
    endcase
  end

  pyrd_front #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_level (q_level),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  pyrd_fifo #(
    .W     ($bits(work_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_entry),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty),
    .level (q_level)
  );

  assign q_head = work_t'(q_dout);

  pyrd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .o_full  (o_full),
    .o_push  (o_push),
    .o_item  (o_item)
  );

  pyrd_fifo #(
    .W     ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .din   (o_item),
    .pop   (out_pop),
    .dout  (o_dout),
    .full  (o_full),
    .empty (out_empty),
    .level (o_level)
  );

  assign out_data = out_item_t'(o_dout);

  a_work_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("work queue overflow");

  a_out_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_empty |-> (o_level == '0))
    else $error("result queue level disagrees with empty");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (q_level == LVW'(QUEUE_DEPTH)) |-> in_full)
    else $error("input accepted with work queue full");

endmodule

[dv/packed_yuv_reorder_deinterlace_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the UYVY reorder deinterlacer: directed table, then random frames.
module packed_yuv_reorder_deinterlace_core_tb;
  import pyrd_pkg::*;

  localparam int LINE_SLOTS   = MAX_PAIRS_DEF;
  localparam int RANDOM_ITEMS = 525;
  localparam int SETTLE       = 8;
  localparam logic [1:0] BY_PREDICTOR = 2'd3;

  typedef struct packed {
    logic        is_write;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    in_item_t    px;
    logic [1:0]  n_typed;
    out_item_t   exp0;
    out_item_t   exp1;
  } step_row_t;

  localparam step_row_t PLAN [41] = '{
    '{1'b1, REG_ORDER_MODE, 32'(ORDER_YVYU), 32'h0, BY_PREDICTOR, '0, '0},
    '{1'b1, REG_PAIRS, 32'd0, 32'h0, BY_PREDICTOR, '0, '0},
    '{1'b1, REG_LINES, 32'd0, 32'h0, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'hFF00FF00, 2'd0, '0, '0},
    '{1'b0, '0, 32'd0, 32'h78563412, 2'd2,
      '{8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0},
      '{8'h34, 8'h56, 8'h78, 8'h12, 1'b1, 1'b1}},
    '{1'b1, REG_ORDER_MODE, 32'(ORDER_VYUY), 32'h0, BY_PREDICTOR, '0, '0},
    '{1'b1, REG_PAIRS, 32'd1, 32'h0, BY_PREDICTOR, '0, '0},
    '{1'b1, REG_LINES, 32'd3, 32'h0, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'hFFFFFFFF, 2'd0, '0, '0},
    '{1'b0, '0, 32'd0, 32'h00000000, 2'd1,
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0}, '0},
    '{1'b0, '0, 32'd0, 32'hFFFFFFFF, 2'd2,
      '{8'h80, 8'h80, 8'h80, 8'h80, 1'b0, 1'b0},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}},
    '{1'b1, REG_ORDER_MODE, 32'(ORDER_YVYU), 32'h0, BY_PREDICTOR, '0, '0},
    '{1'b1, REG_PAIRS, 32'd2, 32'h0, BY_PREDICTOR, '0, '0},
    '{1'b1, REG_LINES, 32'd3, 32'h0, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'hA5C30F96, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'h1E2D3C4B, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'hF00F55AA, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'h01020408, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'h80402010, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'h7F8001FE, BY_PREDICTOR, '0, '0},
    '{1'b1, REG_LINES, 32'd4095, 32'h0, BY_PREDICTOR, '0, '0},
    '{1'b1, REG_PAIRS, 32'd1, 32'h0, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'h3C5A96E1, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'h00FF00FF, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'h6B2ED471, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'h9F1047AC, BY_PREDICTOR, '0, '0},
    '{1'b1, REG_LINES, 32'd2, 32'h0, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'h5511AA22, BY_PREDICTOR, '0, '0},
    '{1'b1, REG_LINES, 32'd3, 32'h0, BY_PREDICTOR, '0, '0},
    '{1'b1, REG_PAIRS, 32'd2047, 32'h0, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'h0F1E2D3C, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'hC3B4A596, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'h87786954, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'h4B5A6978, BY_PREDICTOR, '0, '0},
    '{1'b1, REG_PAIRS, 32'd2, 32'h0, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'hE1D2C3B4, BY_PREDICTOR, '0, '0},
    '{1'b1, REG_ORDER_MODE, 32'(ORDER_VYUY), 32'h0, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'h2468ACE0, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'hFDB97531, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'h13579BDF, BY_PREDICTOR, '0, '0},
    '{1'b0, '0, 32'd0, 32'hECA86420, BY_PREDICTOR, '0, '0}
  };

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_push     = 1'b0;
  logic              in_full;
  in_item_t          in_data     = '0;
  logic              out_empty;
  logic              out_pop     = 1'b0;
  out_item_t         out_data;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [DATA_W-1:0] cfg_pwdata  = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  logic               mode_sh;
  logic [PAIRS_W-1:0] pairs_sh;
  logic [LINES_W-1:0] lines_sh;
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic [31:0]        above_line [LINE_SLOTS];
  logic [31:0]        center_line [LINE_SLOTS];
  out_item_t          awaited_pixels[$];
  int                 failures = 0;
  bit                 steady = 1'b0;

  packed_yuv_reorder_deinterlace_core #(.MAX_PAIRS(MAX_PAIRS_DEF)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_data    (in_data),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < 10);
  endfunction

  function automatic int unsigned live_pairs();
    if (pairs_sh == 0) return 1;
    if (pairs_sh > LINE_SLOTS) return LINE_SLOTS;
    return pairs_sh;
  endfunction

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] vblend(input logic [31:0] up, input logic [31:0] mid,
                                         input logic [31:0] dn);
    logic [31:0] w;
    logic [8:0]  half;
    logic [8:0]  tot;
    for (int k = 0; k < 4; k++) begin
      half = ({1'b0, up[8*k +: 8]} + {1'b0, dn[8*k +: 8]} + 9'd1) >> 1;
      tot = (half + {1'b0, mid[8*k +: 8]} + 9'd1) >> 1;
      w[8*k +: 8] = tot[7:0];
    end
    return w;
  endfunction

  function automatic out_item_t reordered(input logic [31:0] w, input logic last,
                                          input logic eof);
    out_item_t o;
    if (mode_sh == ORDER_YVYU) begin
      o.out_byte0 = w[15:8];
      o.out_byte1 = w[23:16];
      o.out_byte2 = w[31:24];
      o.out_byte3 = w[7:0];
    end else begin
      o.out_byte0 = w[23:16];
      o.out_byte1 = w[15:8];
      o.out_byte2 = w[7:0];
      o.out_byte3 = w[31:24];
    end
    o.last_of_run  = last;
    o.end_of_frame = eof;
    return o;
  endfunction

  task automatic deinterlace_step(input in_item_t px, output int n, output out_item_t r0,
                                  output out_item_t r1);
    logic [31:0] cur;
    logic [31:0] up;
    logic [31:0] mid;
    int unsigned lines;
    int unsigned slot;
    bit          last_row;
    bit          last_col;
    cur = {px.in_y1, px.in_v, px.in_y0, px.in_u};
    lines = (lines_sh < 2) ? 2 : lines_sh;
    slot = (col_pos >= LINE_SLOTS) ? LINE_SLOTS - 1 : col_pos;
    last_row = row_pos >= lines - 1;
    last_col = col_pos + 1 >= live_pairs();
    up = above_line[slot];
    mid = center_line[slot];
    n = 0;
    r0 = '0;
    r1 = '0;
    if (row_pos >= 1) begin
      r0 = reordered((row_pos == 1) ? mid : vblend(up, mid, cur), !last_row, 1'b0);
      n = 1;
      if (last_row) begin
        r1 = reordered(cur, 1'b1, last_col);
        n = 2;
      end
    end
    above_line[slot] = mid;
    center_line[slot] = cur;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : (row_pos + 1) & 32'hFFF;
    end else begin
      col_pos++;
    end
  endtask

  task automatic push_pixel(input in_item_t px, input logic [1:0] n_typed = BY_PREDICTOR,
                            input out_item_t t0 = '0, input out_item_t t1 = '0);
    int        n;
    out_item_t r0;
    out_item_t r1;
    while (take_break()) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_full);
    deinterlace_step(px, n, r0, r1);
    if (n_typed != BY_PREDICTOR) begin
      n = n_typed;
      r0 = t0;
      r1 = t1;
    end
    if (n >= 1) awaited_pixels.push_back(r0);
    if (n == 2) awaited_pixels.push_back(r1);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_W'(4 * idx);
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_ORDER_MODE: mode_sh = value[0];
      REG_PAIRS:      pairs_sh = value[PAIRS_W-1:0];
      REG_LINES:      lines_sh = value[LINES_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle_block();
    in_push <= 1'b0;
    while (awaited_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic log_failure(input string what, input out_item_t want, input out_item_t got);
    failures++;
    if (failures <= 10)
      $display("%0t %s: want %h %h %h %h last %b eof %b, got %h %h %h %h last %b eof %b",
               $realtime, what, want.out_byte0, want.out_byte1, want.out_byte2,
               want.out_byte3, want.last_of_run, want.end_of_frame, got.out_byte0,
               got.out_byte1, got.out_byte2, got.out_byte3, got.last_of_run,
               got.end_of_frame);
  endtask

  always @(negedge clk) begin
    out_pop <= rst_n && !take_break();
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (awaited_pixels.size() == 0) begin
        log_failure("unexpected result", '0, out_data);
      end else begin
        want = awaited_pixels.pop_front();
        if (out_data.out_byte0 !== want.out_byte0 || out_data.out_byte1 !== want.out_byte1 ||
            out_data.out_byte2 !== want.out_byte2 || out_data.out_byte3 !== want.out_byte3 ||
            out_data.last_of_run !== want.last_of_run ||
            out_data.end_of_frame !== want.end_of_frame)
          log_failure("mismatch", want, out_data);
      end
    end
  end

  initial begin : stimulus
    int          sent;
    int          burst;
    bit          fresh_frame;
    int unsigned pairs_pick;
    int unsigned lines_pick;
    in_item_t    px;
    mode_sh = ORDER_YVYU;
    pairs_sh = PAIRS_RESET;
    lines_sh = LINES_RESET;
    col_pos = 0;
    row_pos = 0;
    for (int i = 0; i < LINE_SLOTS; i++) begin
      above_line[i] = '0;
      center_line[i] = '0;
    end
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (PLAN[i]) begin
      if (PLAN[i].is_write) begin
        settle_block();
        write_reg(PLAN[i].reg_idx, PLAN[i].value);
      end else begin
        push_pixel(PLAN[i].px, PLAN[i].n_typed, PLAN[i].exp0, PLAN[i].exp1);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle_block();
      fresh_frame = (col_pos == 0 && row_pos == 0);
      case ($urandom_range(0, 15))
        0:       pairs_pick = 0;
        1:       pairs_pick = $urandom_range(1000, 2047);
        2:       pairs_pick = 1;
        default: pairs_pick = $urandom_range(2, 6);
      endcase
      // mid-frame the line may only shrink, so every stored column stays written
      if (!fresh_frame)
        pairs_pick = $urandom_range(0, (live_pairs() < 6) ? live_pairs() : 6);
      case ($urandom_range(0, 15))
        0:       lines_pick = $urandom_range(0, 1);
        1:       lines_pick = 4095;
        2:       lines_pick = $urandom_range(7, 4094);
        default: lines_pick = $urandom_range(2, 6);
      endcase
      write_reg(REG_ORDER_MODE, 32'($urandom_range(0, 1)));
      write_reg(REG_PAIRS, pairs_pick);
      write_reg(REG_LINES, lines_pick);
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        steady = (sent >= 200 && sent < 320);
        px = '{random_byte(), random_byte(), random_byte(), random_byte()};
        push_pixel(px);
        sent++;
      end
    end
    steady = 1'b0;
    in_push <= 1'b0;

    while (awaited_pixels.size() != 0) @(posedge clk);
    repeat (4 * SETTLE) @(posedge clk);
    if (failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
